// ===== rtl/core/lmcr_pkg.sv =====
package lmcr_pkg;

  // Coefficient and exponential formats
  localparam int unsigned COEF_W = 24;
  localparam int unsigned EXP_FRAC = 30;
  localparam int unsigned EXP_W = EXP_FRAC + 1;
  localparam longint EXP_ONE = 64'sd1 << EXP_FRAC;
  localparam longint EXP_HALF = EXP_ONE >>> 1;
  localparam int unsigned EXP_INT_MAX = 24;
  localparam int unsigned EXP_INT_N = 32;
  localparam int unsigned EXP_TABLE_DEPTH_DEF = 256;
  localparam int unsigned EXP_LAT = 4;

  // Reciprocal divider: (2^24 + a/2) / a
  localparam int unsigned INV_NW = 26;
  localparam int unsigned INV_QW = 25;
  localparam int unsigned INV_LAT = INV_QW + 1;

  // Centroid divider: |num| / den, quotient saturates
  localparam int unsigned DQ_NW = 57;
  localparam int unsigned DQ_DW = 32;
  localparam int unsigned DQ_QW = 26;
  localparam int unsigned DQ_LAT = DQ_QW + 1;

  typedef struct packed {
    logic              coded;
    logic              degen;
    logic              outside;
    logic              below;
    logic              flat;
    logic [COEF_W-1:0] l;
    logic [COEF_W-1:0] u;
    logic [COEF_W-1:0] y;
    logic [COEF_W-1:0] mid;
    logic [COEF_W-1:0] d;
    logic [COEF_W-1:0] g;
    logic [COEF_W-1:0] s;
    logic [COEF_W-2:0] halfd;
    logic [COEF_W:0]   bsmall;
  } meta_t;

  typedef struct packed {
    logic              coded;
    logic              degen;
    logic              outside;
    logic              below;
    logic              flat;
    logic              dpos;
    logic              neg;
    logic [COEF_W-1:0] l;
    logic [COEF_W-1:0] u;
    logic [COEF_W-1:0] y;
    logic [COEF_W-1:0] mid;
    logic [COEF_W-2:0] halfd;
    logic [COEF_W:0]   bsmall;
    logic [INV_QW-1:0] inva;
  } fin_t;

  // exp(-i/depth) in Q1.30 by repeated rounded products of r = exp(-1/depth)
  function automatic longint exp_frac_entry(longint r, int unsigned i);
    longint v;
    v = EXP_ONE;
    for (int unsigned k = 0; k < i; k++) begin
      v = (v * r + EXP_HALF) >>> EXP_FRAC;
    end
    return v;
  endfunction

  // exp(-n) in Q1.30, zero for n of EXP_INT_MAX and above
  function automatic longint exp_int_entry(longint r, int unsigned depth, int unsigned n);
    longint e1;
    longint v;
    e1 = exp_frac_entry(r, depth);
    v = EXP_ONE;
    if (n >= EXP_INT_MAX) begin
      v = 0;
    end else begin
      for (int unsigned k = 0; k < n; k++) begin
        v = (v * e1 + EXP_HALF) >>> EXP_FRAC;
      end
    end
    return v;
  endfunction

endpackage

// ===== rtl/core/lmcr_div.sv =====
module lmcr_div import lmcr_pkg::*; #(
  parameter int unsigned NW = DQ_NW,
  parameter int unsigned DW = DQ_DW,
  parameter int unsigned QW = DQ_QW
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic [QW-1:0] quo_o
);

  logic [DW-1:0] rem_q [QW+1];
  logic [DW-1:0] den_q [QW+1];
  logic [QW-1:0] low_q [QW+1];
  logic [QW-1:0] quo_q [QW+1];
  logic [QW:0]   ovf_q;
  logic [DW-1:0] rem0;

  assign rem0 = DW'(num_i[NW-1:QW]);

  // Load the high part; flag a quotient that does not fit
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= rem0;
      low_q[0] <= num_i[QW-1:0];
      quo_q[0] <= '0;
      den_q[0] <= den_i;
      ovf_q[0] <= (rem0 >= den_i);
    end
  end

  for (genvar k = 1; k <= QW; k++) begin : g_step
    logic [DW:0] trial;
    logic [DW:0] diff;
    logic        fits;

    assign trial = {rem_q[k-1], low_q[k-1][QW-1]};
    assign fits  = (trial >= {1'b0, den_q[k-1]});
    assign diff  = trial - {1'b0, den_q[k-1]};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= fits ? diff[DW-1:0] : trial[DW-1:0];
        low_q[k] <= {low_q[k-1][QW-2:0], 1'b0};
        quo_q[k] <= {quo_q[k-1][QW-2:0], fits};
        den_q[k] <= den_q[k-1];
        ovf_q[k] <= ovf_q[k-1];
      end
    end
  end

  assign quo_o = ovf_q[QW] ? {QW{1'b1}} : quo_q[QW];

endmodule

// ===== rtl/core/lmcr_exp.sv =====
module lmcr_exp import lmcr_pkg::*; #(
  parameter int unsigned DEPTH = EXP_TABLE_DEPTH_DEF
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [47:0]      arg_i,
  output logic [EXP_W-1:0] exp_o
);

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned PW = 24 + IW;

  // r = exp(-1/DEPTH) by the series up to the tenth power
  localparam longint HQ  = (EXP_ONE + longint'(DEPTH / 2)) / longint'(DEPTH);
  localparam longint T1  = ((EXP_ONE * HQ) / EXP_ONE) / 1;
  localparam longint T2  = ((T1 * HQ) / EXP_ONE) / 2;
  localparam longint T3  = ((T2 * HQ) / EXP_ONE) / 3;
  localparam longint T4  = ((T3 * HQ) / EXP_ONE) / 4;
  localparam longint T5  = ((T4 * HQ) / EXP_ONE) / 5;
  localparam longint T6  = ((T5 * HQ) / EXP_ONE) / 6;
  localparam longint T7  = ((T6 * HQ) / EXP_ONE) / 7;
  localparam longint T8  = ((T7 * HQ) / EXP_ONE) / 8;
  localparam longint T9  = ((T8 * HQ) / EXP_ONE) / 9;
  localparam longint T10 = ((T9 * HQ) / EXP_ONE) / 10;
  localparam longint R   = EXP_ONE - T1 + T2 - T3 + T4 - T5 + T6 - T7 + T8 - T9 + T10;

  logic [EXP_W-1:0] lo_tab  [DEPTH];
  logic [EXP_W-1:0] hi_tab  [DEPTH];
  logic [EXP_W-1:0] int_tab [EXP_INT_N];

  for (genvar i = 0; i < DEPTH; i++) begin : g_frac
    localparam longint LO_V = exp_frac_entry(R, i);
    localparam longint HI_V = exp_frac_entry(R, i + 1);
    assign lo_tab[i] = EXP_W'(LO_V);
    assign hi_tab[i] = EXP_W'(HI_V);
  end

  for (genvar n = 0; n < EXP_INT_N; n++) begin : g_int
    localparam longint INT_V = exp_int_entry(R, DEPTH, n);
    assign int_tab[n] = EXP_W'(INT_V);
  end

  // Stage 1: split into integer and fraction, scale fraction to table
  logic [PW-1:0]    pos;
  logic [IW-1:0]    idx1_q;
  logic [23:0]      w1_q;
  logic [4:0]       n1_q;
  logic             z1_q;
  // Stage 2: table read
  logic [EXP_W-1:0] lo2_q;
  logic [EXP_W-1:0] diff2_q;
  logic [23:0]      w2_q;
  logic [4:0]       n2_q;
  logic             z2_q;
  // Stage 3: interpolate
  logic [54:0]      ipol;
  logic [EXP_W-1:0] v3_q;
  logic [4:0]       n3_q;
  logic             z3_q;
  // Stage 4: scale by exp(-n)
  logic [61:0]      scaled;
  logic [EXP_W-1:0] e4_q;

  assign pos    = {{IW{1'b0}}, arg_i[23:0]} * PW'(DEPTH);
  assign ipol   = {24'b0, diff2_q} * {31'b0, w2_q};
  assign scaled = {31'b0, int_tab[n3_q]} * {31'b0, v3_q};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      idx1_q  <= pos[PW-1:24];
      w1_q    <= pos[23:0];
      n1_q    <= arg_i[28:24];
      z1_q    <= |arg_i[47:29];
      lo2_q   <= lo_tab[idx1_q];
      diff2_q <= lo_tab[idx1_q] - hi_tab[idx1_q];
      w2_q    <= w1_q;
      n2_q    <= n1_q;
      z2_q    <= z1_q;
      v3_q    <= lo2_q - ipol[54:24];
      n3_q    <= n2_q;
      z3_q    <= z2_q;
      e4_q    <= z3_q ? '0 : scaled[60:30];
    end
  end

  assign exp_o = e4_q;

endmodule

// ===== rtl/core/laplacian_mmse_coeff_reconstruct_unit.sv =====
// Laplacian MMSE coefficient reconstruction, fully pipelined.
// 58 register stages, from the input register to the output register. The
// 25-step reciprocal divider and the 26-step centroid divider set that depth.
// Throughput: one item per cycle; the whole pipeline holds while a result waits.
// Reset clears the stage valid bits only; no table or memory needs clearing.
module laplacian_mmse_coeff_reconstruct_unit import lmcr_pkg::*; #(
  parameter int unsigned EXP_TABLE_DEPTH = EXP_TABLE_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [COEF_W-1:0] lower_bound_i,
  input  logic [COEF_W-1:0] upper_bound_i,
  input  logic [COEF_W-1:0] side_value_i,
  input  logic [COEF_W-1:0] laplace_alpha_i,
  input  logic              band_coded_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [COEF_W-1:0] recon_value_o,
  output logic              degenerate_o
);

  // Stage numbering: stage 1 is the input register. The reciprocal is ready
  // at the align stage, where bin data and the exponentials meet it.
  localparam int unsigned ALIGN_ST = 1 + INV_LAT;
  localparam int unsigned MD_LEN   = INV_LAT - 3;
  localparam int unsigned ED_LEN   = INV_LAT - 2 - EXP_LAT;
  localparam int unsigned FD_LEN   = DQ_LAT;
  localparam int unsigned PIPE_LEN = ALIGN_ST + 2 + DQ_LAT + 2;

  logic                en;
  logic [PIPE_LEN-1:0] vld_q;

  // One valid bit per stage; everything advances together
  assign en          = out_ready_i | ~vld_q[PIPE_LEN-1];
  assign in_ready_o  = en;
  assign out_valid_o = vld_q[PIPE_LEN-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[PIPE_LEN-2:0], in_valid_i};
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: capture the item
  // ---------------------------------------------------------------------
  logic [COEF_W-1:0] l1_q, u1_q, y1_q, a1_q;
  logic              c1_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      l1_q <= lower_bound_i;
      u1_q <= upper_bound_i;
      y1_q <= side_value_i;
      a1_q <= laplace_alpha_i;
      c1_q <= band_coded_i;
    end
  end

  // Bin geometry and case selection
  logic signed [COEF_W:0] d1, g1, s1, sum1;
  logic                   below1, outside1, degen1;
  logic [INV_NW-1:0]      inv_num;
  logic [INV_QW-1:0]      inva;
  meta_t                  m1;

  assign d1   = $signed({u1_q[COEF_W-1], u1_q}) - $signed({l1_q[COEF_W-1], l1_q});
  assign g1   = $signed({y1_q[COEF_W-1], y1_q}) - $signed({l1_q[COEF_W-1], l1_q});
  assign s1   = $signed({u1_q[COEF_W-1], u1_q}) - $signed({y1_q[COEF_W-1], y1_q});
  assign sum1 = $signed({l1_q[COEF_W-1], l1_q}) + $signed({u1_q[COEF_W-1], u1_q});

  assign below1   = $signed(y1_q) < $signed(l1_q);
  assign outside1 = below1 | ($signed(y1_q) >= $signed(u1_q));
  assign degen1   = (a1_q == '0) | d1[COEF_W] | (d1 == '0);

  // Rounded reciprocal numerator: 2^24 + a/2
  assign inv_num = {2'b01, {COEF_W{1'b0}}} + {3'b000, a1_q[COEF_W-1:1]};

  lmcr_div #(
    .NW (INV_NW),
    .DW (COEF_W),
    .QW (INV_QW)
  ) u_div_inv (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (inv_num),
    .den_i (a1_q),
    .quo_o (inva)
  );

  always_comb begin
    m1         = '0;
    m1.coded   = c1_q;
    m1.degen   = degen1;
    m1.outside = outside1;
    m1.below   = below1;
    m1.l       = l1_q;
    m1.u       = u1_q;
    m1.y       = y1_q;
    m1.mid     = sum1[COEF_W:1];
    m1.d       = d1[COEF_W-1:0];
    m1.g       = g1[COEF_W-1:0];
    m1.s       = s1[COEF_W-1:0];
    m1.halfd   = d1[COEF_W-1:1];
  end

  // ---------------------------------------------------------------------
  // Stage 2 -> 3: alpha times width and the two distances
  // ---------------------------------------------------------------------
  meta_t             m2_q, m3_q, m4_q;
  logic [COEF_W-1:0] a2_q;
  logic [47:0]       td3_q, tg3_q, ts3_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      m2_q  <= m1;
      a2_q  <= a1_q;
      m3_q  <= m2_q;
      td3_q <= {24'b0, a2_q} * {24'b0, m2_q.d};
      tg3_q <= {24'b0, a2_q} * {24'b0, m2_q.g};
      ts3_q <= {24'b0, a2_q} * {24'b0, m2_q.s};
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3 -> 5: nearly flat test and series form of the offset;
  // the exponentials start here as well
  // ---------------------------------------------------------------------
  logic [47:0]          exp_arg_a;
  logic [EXP_W-1:0]     exp_a, exp_b;
  logic                 small3;
  logic [39:0]          psm4_q;
  logic                 small4_q;
  logic [28:0]          third;
  logic signed [COEF_W:0] bsmall4;
  meta_t                m5;

  assign exp_arg_a = m3_q.outside ? td3_q : tg3_q;
  assign small3    = (td3_q[47:16] == '0);

  lmcr_exp #(
    .DEPTH (EXP_TABLE_DEPTH)
  ) u_exp_a (
    .clk_i (clk_i),
    .en_i  (en),
    .arg_i (exp_arg_a),
    .exp_o (exp_a)
  );

  lmcr_exp #(
    .DEPTH (EXP_TABLE_DEPTH)
  ) u_exp_b (
    .clk_i (clk_i),
    .en_i  (en),
    .arg_i (ts3_q),
    .exp_o (exp_b)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      m4_q     <= m3_q;
      small4_q <= small3;
      psm4_q   <= {16'b0, m3_q.d} * {24'b0, td3_q[15:0]};
    end
  end

  // d*td / (12 * 2^24) as (d*td >> 26) / 3, the divide by three by reciprocal
  assign third   = {15'b0, psm4_q[39:26]} * 29'd21846;
  assign bsmall4 = $signed({2'b00, m4_q.halfd}) - $signed({12'b0, third[28:16]});

  always_comb begin
    m5        = m4_q;
    m5.flat   = small4_q;
    m5.bsmall = bsmall4;
  end

  // ---------------------------------------------------------------------
  // Delay lines up to the align stage
  // ---------------------------------------------------------------------
  meta_t            md_q  [MD_LEN];
  logic [EXP_W-1:0] eda_q [ED_LEN];
  logic [EXP_W-1:0] edb_q [ED_LEN];

  always_ff @(posedge clk_i) begin
    if (en) begin
      md_q[0]  <= m5;
      eda_q[0] <= exp_a;
      edb_q[0] <= exp_b;
      for (int k = 1; k < MD_LEN; k++) begin
        md_q[k] <= md_q[k-1];
      end
      for (int k = 1; k < ED_LEN; k++) begin
        eda_q[k] <= eda_q[k-1];
        edb_q[k] <= edb_q[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Align stage: numerator products and denominator.
  // Outside the bin: d*e(ad) over 1 - e(ad).
  // Inside the bin: (g+1/a)e(ag) - (s+1/a)e(as) over 2 - e(ag) - e(as).
  // ---------------------------------------------------------------------
  meta_t            ma;
  logic [EXP_W-1:0] ea, eb;
  logic [25:0]      op_a, op_b;
  logic [31:0]      den_a;
  logic [56:0]      pa28_q, pb28_q;
  logic [31:0]      den28_q;
  fin_t             fa, f28_q;

  assign ma = md_q[MD_LEN-1];
  assign ea = eda_q[ED_LEN-1];
  assign eb = edb_q[ED_LEN-1];

  assign op_a  = ma.outside ? {2'b00, ma.d} : ({2'b00, ma.g} + {1'b0, inva});
  assign op_b  = ma.outside ? '0 : ({2'b00, ma.s} + {1'b0, inva});
  assign den_a = ma.outside ? (32'h4000_0000 - {1'b0, ea})
                            : (32'h8000_0000 - {1'b0, ea} - {1'b0, eb});

  always_comb begin
    fa         = '0;
    fa.coded   = ma.coded;
    fa.degen   = ma.degen;
    fa.outside = ma.outside;
    fa.below   = ma.below;
    fa.flat    = ma.flat;
    fa.dpos    = (den_a != '0);
    fa.l       = ma.l;
    fa.u       = ma.u;
    fa.y       = ma.y;
    fa.mid     = ma.mid;
    fa.halfd   = ma.halfd;
    fa.bsmall  = ma.bsmall;
    fa.inva    = inva;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pa28_q  <= {31'b0, op_a} * {26'b0, ea};
      pb28_q  <= {31'b0, op_b} * {26'b0, eb};
      den28_q <= den_a;
      f28_q   <= fa;
    end
  end

  // Difference of the two products, then magnitude into the divider
  logic [57:0]      num29_q;
  logic [31:0]      den29_q;
  fin_t             f29_q, f29;
  logic [57:0]      num_neg;
  logic [DQ_NW-1:0] num_mag;
  logic [DQ_QW-1:0] quo;

  always_ff @(posedge clk_i) begin
    if (en) begin
      num29_q <= {1'b0, pa28_q} - {1'b0, pb28_q};
      den29_q <= den28_q;
      f29_q   <= f28_q;
    end
  end

  assign num_neg = -num29_q;
  assign num_mag = num29_q[57] ? num_neg[DQ_NW-1:0] : num29_q[DQ_NW-1:0];

  always_comb begin
    f29     = f29_q;
    f29.neg = num29_q[57];
  end

  lmcr_div #(
    .NW (DQ_NW),
    .DW (DQ_DW),
    .QW (DQ_QW)
  ) u_div_cen (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (num_mag),
    .den_i (den29_q),
    .quo_o (quo)
  );

  fin_t fd_q [FD_LEN];

  always_ff @(posedge clk_i) begin
    if (en) begin
      fd_q[0] <= f29;
      for (int k = 1; k < FD_LEN; k++) begin
        fd_q[k] <= fd_q[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Raw offset (outside) and raw centroid (inside)
  // ---------------------------------------------------------------------
  fin_t               ff, f57_q;
  logic signed [27:0] b_raw, x_raw, b57_q, x57_q;
  logic signed [27:0] y_ext, mid_ext;

  assign ff      = fd_q[FD_LEN-1];
  assign y_ext   = $signed({{4{ff.y[COEF_W-1]}}, ff.y});
  assign mid_ext = $signed({{4{ff.mid[COEF_W-1]}}, ff.mid});

  always_comb begin
    if (ff.flat) begin
      b_raw = $signed({{3{ff.bsmall[COEF_W]}}, ff.bsmall});
    end else if (ff.dpos) begin
      b_raw = $signed({3'b000, ff.inva}) - $signed({2'b00, quo});
    end else begin
      b_raw = $signed({5'b00000, ff.halfd});
    end
    if (ff.flat || !ff.dpos) begin
      x_raw = mid_ext;
    end else if (ff.neg) begin
      x_raw = y_ext - $signed({2'b00, quo});
    end else begin
      x_raw = y_ext + $signed({2'b00, quo});
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f57_q <= ff;
      b57_q <= b_raw;
      x57_q <= x_raw;
    end
  end

  // ---------------------------------------------------------------------
  // Clamp, pick the case, drive the output register
  // ---------------------------------------------------------------------
  logic [COEF_W-2:0]  b_clip;
  logic [COEF_W-1:0]  x_out, x_in, recon_d;
  logic signed [27:0] l_ext, u_ext;
  logic [COEF_W-1:0]  recon_q;
  logic               degen_q;

  assign l_ext = $signed({{4{f57_q.l[COEF_W-1]}}, f57_q.l});
  assign u_ext = $signed({{4{f57_q.u[COEF_W-1]}}, f57_q.u});

  always_comb begin
    if (b57_q < 0) begin
      b_clip = '0;
    end else if (b57_q > $signed({5'b00000, f57_q.halfd})) begin
      b_clip = f57_q.halfd;
    end else begin
      b_clip = b57_q[COEF_W-2:0];
    end
    x_out = f57_q.below ? (f57_q.l + {1'b0, b_clip}) : (f57_q.u - {1'b0, b_clip});

    if (x57_q < l_ext) begin
      x_in = f57_q.l;
    end else if (x57_q > u_ext) begin
      x_in = f57_q.u;
    end else begin
      x_in = x57_q[COEF_W-1:0];
    end

    if (!f57_q.coded) begin
      recon_d = f57_q.y;
    end else if (f57_q.degen) begin
      recon_d = f57_q.mid;
    end else if (f57_q.outside) begin
      recon_d = x_out;
    end else begin
      recon_d = x_in;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      recon_q <= recon_d;
      degen_q <= f57_q.coded & f57_q.degen;
    end
  end

  assign recon_value_o = recon_q;
  assign degenerate_o  = degen_q;

endmodule
